// ===== src/tws_pkg.sv =====
package tws_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int PHASES        = 2 * BITS_PER_BYTE + 2;
  localparam int PHASE_W       = $clog2(PHASES);
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  // bus commands
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  // job kinds handed from front to back
  localparam logic [1:0] JOB_SHIFT_OUT = 2'd0;
  localparam logic [1:0] JOB_SHIFT_IN  = 2'd1;
  localparam logic [1:0] JOB_CLOSE     = 2'd2;
  localparam logic [1:0] JOB_REJECT    = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic [BITS_PER_BYTE-1:0] data;
  } job_t;

  typedef struct packed {
    logic                     select_low;
    logic                     clock_level;
    logic                     data_level;
    logic                     drive_data;
    logic [BITS_PER_BYTE-1:0] read_byte;
    logic                     read_valid;
    logic                     error_flag;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== src/tws_in_if.sv =====
interface tws_in_if;
  import tws_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [BITS_PER_BYTE-1:0] byte_value;
  logic [BITS_PER_BYTE-1:0] line_samples;

  modport source (output valid, cmd, byte_value, line_samples, input ready);
  modport sink (input valid, cmd, byte_value, line_samples, output ready);
endinterface

// ===== src/tws_out_if.sv =====
interface tws_out_if;
  import tws_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     select_low;
  logic                     clock_level;
  logic                     data_level;
  logic                     drive_data;
  logic [BITS_PER_BYTE-1:0] read_byte;
  logic                     read_valid;
  logic                     error_flag;
  logic                     last;

  modport source (
    output valid, select_low, clock_level, data_level, drive_data,
           read_byte, read_valid, error_flag, last,
    input  ready
  );
  modport sink (
    input  valid, select_low, clock_level, data_level, drive_data,
           read_byte, read_valid, error_flag, last,
    output ready
  );
endinterface

// ===== src/tws_front.sv =====
module tws_front
  import tws_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  tws_in_if.sink       in_i,
  input  fifo_status_t status_i,
  output logic         push_o,
  output job_t         job_o
);

  logic open_q, open_d;
  logic accept;

  assign in_i.ready = ~status_i.full;
  assign accept     = in_i.valid & in_i.ready;
  assign push_o     = accept;

  always_comb begin
    open_d   = open_q;
    job_o.data = (in_i.cmd == CMD_READ) ? in_i.line_samples : in_i.byte_value;
    case (in_i.cmd)
      CMD_BEGIN: begin
        job_o.kind = JOB_SHIFT_OUT;
        open_d     = 1'b1;
      end
      CMD_WRITE: job_o.kind = open_q ? JOB_SHIFT_OUT : JOB_REJECT;
      CMD_READ:  job_o.kind = open_q ? JOB_SHIFT_IN : JOB_REJECT;
      CMD_END: begin
        job_o.kind = JOB_CLOSE;
        open_d     = 1'b0;
      end
      default:   job_o.kind = JOB_REJECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else if (accept) begin
      open_q <= open_d;
    end
  end

endmodule

// ===== src/tws_fifo.sv =====
module tws_fifo
  import tws_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  job_t         job_i,
  input  logic         pop_i,
  output job_t         head_o,
  output fifo_status_t status_o
);

  job_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;

  assign status_o.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== src/tws_back.sv =====
module tws_back
  import tws_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  job_t         head_i,
  input  fifo_status_t status_i,
  output logic         pop_o,
  tws_out_if.source    out_o
);

  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic                 held_q, held_d;
  logic                 out_valid_q;
  result_t              res_q, res_d;
  logic                 load, fire, done;
  logic                 last_phase, bit_phase;
  logic [BIT_IDX_W-1:0] bit_sel;
  logic                 tx_bit;

  assign load       = ~out_valid_q | out_o.ready;
  assign fire       = load & ~status_i.empty;
  assign last_phase = (phase_q == PHASE_W'(PHASES - 1));
  assign bit_phase  = (phase_q != '0) & ~last_phase;
  // odd phase 2i+1 carries bit 7-i, msb first
  assign bit_sel    = ~phase_q[BIT_IDX_W:1];
  assign tx_bit     = head_i.data[bit_sel];

  always_comb begin
    res_d             = '0;
    res_d.select_low  = 1'b1;
    res_d.data_level  = held_q;
    res_d.drive_data  = 1'b1;
    held_d            = held_q;
    done              = 1'b0;
    case (head_i.kind)
      JOB_SHIFT_OUT: begin
        if (bit_phase) begin
          res_d.clock_level = ~phase_q[0];
          if (phase_q[0]) begin
            res_d.data_level = tx_bit;
            held_d           = tx_bit;
          end
        end
        res_d.last = last_phase;
        done       = last_phase;
      end
      JOB_SHIFT_IN: begin
        res_d.drive_data = 1'b0;
        if (bit_phase) begin
          res_d.clock_level = phase_q[0];
        end
        if (last_phase) begin
          res_d.read_byte  = head_i.data;
          res_d.read_valid = 1'b1;
        end
        res_d.last = last_phase;
        done       = last_phase;
      end
      JOB_CLOSE: begin
        res_d.select_low = 1'b0;
        res_d.last       = 1'b1;
        done             = 1'b1;
      end
      default: begin
        res_d.select_low = 1'b0;
        res_d.error_flag = 1'b1;
        res_d.last       = 1'b1;
        done             = 1'b1;
      end
    endcase
    phase_d = done ? '0 : phase_q + 1'b1;
  end

  assign pop_o = fire & done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      held_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= ~status_i.empty;
      end
      if (fire) begin
        phase_q <= phase_d;
        held_q  <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.select_low  = res_q.select_low;
  assign out_o.clock_level = res_q.clock_level;
  assign out_o.data_level  = res_q.data_level;
  assign out_o.drive_data  = res_q.drive_data;
  assign out_o.read_byte   = res_q.read_byte;
  assign out_o.read_valid  = res_q.read_valid;
  assign out_o.error_flag  = res_q.error_flag;
  assign out_o.last        = res_q.last;

endmodule

// ===== src/three_wire_spi_pin_sequencer_core.sv =====
// three-wire half-duplex spi master (mode 0, msb first) that emits one pin
// state per result item. a begin item drops chip select and shifts out an
// opcode, write items shift out a byte, read items release the data line and
// return the sampled byte on the final phase, an end item raises chip select.
// each byte item gives 18 results (last marked) at one result per cycle while
// the sink does not stall; end items and data items outside a transaction
// give a single result. the phase sequencer in the back end produces these
// results. a two-entry job queue sits between the front end and the
// sequencer, so items are taken while earlier ones are still being played
// out, and a registered output stage holds the current pin state while the
// sink stalls.
module three_wire_spi_pin_sequencer_core
  import tws_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tws_in_if.sink    in_i,
  tws_out_if.source out_o
);

  // front to queue
  logic         push;
  job_t         job;
  // queue to back
  job_t         head;
  logic         pop;
  fifo_status_t status;

  // accepts items, tracks whether a transaction is open, classifies each item
  tws_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .status_i (status),
    .push_o   (push),
    .job_o    (job)
  );

  // short job queue decoupling the two sides
  tws_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  // phase sequencer, keeps the held data line level between items
  tws_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .status_i (status),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
